FILE: sv/frs_pkg.sv
// Shared types and constants of the fault recovery sequencer.
// No dependencies; compile first.
`default_nettype none

package frs_pkg;

	localparam int TS_BITS       = 63;
	localparam int SETTLE_NS_W   = 36;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int NS_PER_MS     = 1000 * 1000;
	localparam int SETTLE_MS_RST = 500;
	localparam logic [7:0]  RETRY_MAX_RST   = 8'd3;
	localparam logic [15:0] RETRY_DELAY_RST = 16'd100;
	localparam logic [SETTLE_NS_W-1:0] SETTLE_NS_RST =
		SETTLE_NS_W'(longint'(SETTLE_MS_RST) * longint'(NS_PER_MS));

	typedef enum logic [2:0] {
		CMD_PAUSE   = 3'd0,
		CMD_RETRACT = 3'd1,
		CMD_ESTOP   = 3'd2,
		CMD_RESET   = 3'd3,
		CMD_TRIGGER = 3'd4,
		CMD_BAND    = 3'd5,
		CMD_TICK    = 3'd6,
		CMD_OUTCOME = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_HOLD    = 3'd1,
		MODE_RETRACT = 3'd2,
		MODE_WAIT    = 3'd3,
		MODE_READY   = 3'd4,
		MODE_ESTOP   = 3'd5
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SETTLE      = 2'd0,
		CFG_RETRY_MAX   = 2'd1,
		CFG_RETRY_DELAY = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0]         command;
		logic               within_band;
		logic [TS_BITS-1:0] now_time_ns;
		logic               attempt_success;
	} in_item_t;

	typedef struct packed {
		logic [2:0] state_code;
		logic       hold_active;
		logic       retreat_done;
		logic       retry_running;
		logic       attempt_request;
		logic [7:0] attempt_index;
	} out_item_t;

	typedef struct packed {
		logic [SETTLE_NS_W-1:0] settle_ns;
		logic [7:0]             retry_max;
		logic [15:0]            retry_delay;
	} cfg_t;

endpackage

`default_nettype wire

FILE: sv/frs_engine.sv
// Sequencer state and next-state logic for one item per cycle, advancing only on commit.
// Depends on frs_pkg; instantiated by fault_recovery_sequencer_top.
`default_nettype none

module frs_engine #(
	parameter int TimestampBits = frs_pkg::TS_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             commit,
	input  frs_pkg::in_item_t     item,
	input  frs_pkg::cfg_t         cfg,
	output frs_pkg::out_item_t    result
);
	import frs_pkg::*;

	mode_t                    mode_q, mode_nxt;
	logic                     hold_q, hold_nxt;
	logic                     retreat_q, retreat_nxt;
	logic                     retry_on_q, retry_on_nxt;
	logic                     awaiting_q, awaiting_nxt;
	logic [TimestampBits-1:0] start_q, start_nxt;
	logic [7:0]               count_q, count_nxt;
	logic [15:0]              delay_q, delay_nxt;
	logic                     request;

	logic [63:0]              now_ext;
	logic [TimestampBits-1:0] now_m;
	logic [TimestampBits-1:0] base;
	logic [TimestampBits-1:0] elapsed;

	assign now_ext = {1'b0, item.now_time_ns};
	assign now_m   = now_ext[TimestampBits-1:0];
	assign base    = (start_q == '0) ? now_m : start_q;
	assign elapsed = now_m - base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			hold_q     <= 1'b0;
			retreat_q  <= 1'b1;
			retry_on_q <= 1'b0;
			awaiting_q <= 1'b0;
			start_q    <= '0;
			count_q    <= '0;
			delay_q    <= '0;
		end else if (commit) begin
			mode_q     <= mode_nxt;
			hold_q     <= hold_nxt;
			retreat_q  <= retreat_nxt;
			retry_on_q <= retry_on_nxt;
			awaiting_q <= awaiting_nxt;
			start_q    <= start_nxt;
			count_q    <= count_nxt;
			delay_q    <= delay_nxt;
		end
	end

	always_comb begin
		mode_nxt     = mode_q;
		hold_nxt     = hold_q;
		retreat_nxt  = retreat_q;
		retry_on_nxt = retry_on_q;
		awaiting_nxt = awaiting_q;
		start_nxt    = start_q;
		count_nxt    = count_q;
		delay_nxt    = delay_q;
		request      = 1'b0;
		case (cmd_t'(item.command))
			CMD_PAUSE: begin
				hold_nxt    = 1'b1;
				retreat_nxt = 1'b0;
				start_nxt   = '0;
				mode_nxt    = MODE_HOLD;
			end
			CMD_RETRACT: begin
				hold_nxt    = 1'b0;
				retreat_nxt = 1'b1;
				start_nxt   = '0;
				mode_nxt    = MODE_RETRACT;
			end
			CMD_ESTOP: begin
				retry_on_nxt = 1'b0;
				awaiting_nxt = 1'b0;
				hold_nxt     = 1'b0;
				retreat_nxt  = 1'b0;
				start_nxt    = '0;
				mode_nxt     = MODE_ESTOP;
			end
			CMD_RESET: begin
				retry_on_nxt = 1'b0;
				awaiting_nxt = 1'b0;
				hold_nxt     = 1'b0;
				retreat_nxt  = 1'b1;
				start_nxt    = '0;
				mode_nxt     = MODE_IDLE;
			end
			CMD_TRIGGER: begin
				awaiting_nxt = 1'b0;
				count_nxt    = '0;
				delay_nxt    = cfg.retry_delay;
				retry_on_nxt = (cfg.retry_max != '0);
				start_nxt    = '0;
				mode_nxt     = MODE_HOLD;
			end
			CMD_BAND: begin
				if (mode_q != MODE_ESTOP && mode_q != MODE_IDLE) begin
					if (!item.within_band) begin
						start_nxt = '0;
						if (mode_q == MODE_READY) begin
							mode_nxt = MODE_WAIT;
						end
					end else begin
						start_nxt = base;
						if (mode_q inside {MODE_RETRACT, MODE_HOLD, MODE_WAIT}) begin
							mode_nxt = MODE_WAIT;
						end
						if (now_m >= base && 64'(elapsed) >= 64'(cfg.settle_ns)) begin
							hold_nxt    = 1'b0;
							retreat_nxt = 1'b1;
							mode_nxt    = MODE_READY;
						end
					end
				end
			end
			CMD_TICK: begin
				if (retry_on_q && !awaiting_q) begin
					if (delay_q > 16'd1) begin
						delay_nxt = delay_q - 16'd1;
					end else if (count_q >= cfg.retry_max) begin
						delay_nxt    = '0;
						retry_on_nxt = 1'b0;
						awaiting_nxt = 1'b0;
					end else begin
						delay_nxt    = '0;
						count_nxt    = count_q + 8'd1;
						awaiting_nxt = 1'b1;
						request      = 1'b1;
					end
				end
			end
			CMD_OUTCOME: begin
				if (retry_on_q && awaiting_q) begin
					awaiting_nxt = 1'b0;
					if (item.attempt_success) begin
						retry_on_nxt = 1'b0;
						hold_nxt     = 1'b1;
						retreat_nxt  = 1'b0;
						start_nxt    = '0;
						mode_nxt     = MODE_WAIT;
					end else if (count_q >= cfg.retry_max) begin
						retry_on_nxt = 1'b0;
					end else begin
						delay_nxt = cfg.retry_delay;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign result.state_code      = mode_nxt;
	assign result.hold_active     = hold_nxt;
	assign result.retreat_done    = retreat_nxt;
	assign result.retry_running   = retry_on_nxt;
	assign result.attempt_request = request;
	assign result.attempt_index   = count_nxt;

	a_await_needs_retry: assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_q |-> retry_on_q)
		else $error("outcome pending with retry engine stopped");

	a_request_sets_await: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && request) |=> awaiting_q)
		else $error("attempt request not followed by pending outcome");

	a_estop_no_retry: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_ESTOP) |-> !retry_on_q)
		else $error("retry engine running while estop latched");

	a_ready_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_READY) |-> (!hold_q && retreat_q))
		else $error("ready with hold set or retreat clear");

	a_unset_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE || mode_q == MODE_ESTOP) |-> (start_q == '0))
		else $error("stable timestamp set while idle or estop");

endmodule

`default_nettype wire

FILE: sv/fault_recovery_sequencer_top.sv
// Top level of the fault recovery sequencer: config registers, input and result stages.
// Depends on frs_pkg and frs_engine.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------
//  in       | in_valid / in_stall     | in_item  (command and operands)
//  out      | out_valid / out_stall   | out_item (state, flags, attempt)
//  config   | cfg_we                  | cfg_index, cfg_wdata
//
// One item per cycle unless the result is stalled; an item's result is registered as the
// item leaves the input register. The state update and the 63-bit settle compare sit
// between the input and result registers. Reset returns to idle with default config
// values. A stalled result holds; the input register accepts while it is empty or
// while its item moves into the result register.
`default_nettype none

module fault_recovery_sequencer_top #(
	parameter int TimestampBits = frs_pkg::TS_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output      logic                           in_stall,
	input  frs_pkg::in_item_t                   in_item,
	output      logic                           out_valid,
	input  wire logic                           out_stall,
	output frs_pkg::out_item_t                  out_item,
	input  wire logic                           cfg_we,
	input  wire logic [frs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [frs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import frs_pkg::*;

	cfg_t                   cfg_q;
	logic [SETTLE_NS_W-1:0] settle_ns_w;
	in_item_t               item_s1;
	logic                   valid_s1;
	out_item_t              res_s2;
	logic                   valid_s2;
	out_item_t              res_d;
	logic                   commit;

	assign settle_ns_w = SETTLE_NS_W'(cfg_wdata) * SETTLE_NS_W'(NS_PER_MS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ns   <= SETTLE_NS_RST;
			cfg_q.retry_max   <= RETRY_MAX_RST;
			cfg_q.retry_delay <= RETRY_DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SETTLE:      cfg_q.settle_ns   <= settle_ns_w;
				CFG_RETRY_MAX:   cfg_q.retry_max   <= cfg_wdata[7:0];
				CFG_RETRY_DELAY: cfg_q.retry_delay <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign commit   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (commit) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
		if (commit) begin
			res_s2 <= res_d;
		end
	end

	frs_engine #(
		.TimestampBits(TimestampBits)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_d)
	);

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

endmodule

`default_nettype wire

FILE: bench/tb_fault_recovery_sequencer_top.sv
// Testbench of fault_recovery_sequencer_top: drives command items, predicts every result
// and compares it field by field. Depends on frs_pkg and the block's RTL.
`default_nettype none

module tb_fault_recovery_sequencer_top;
	import frs_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_item = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_item;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SETTLE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	fault_recovery_sequencer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	in_item_t  pending_cmds[$];
	out_item_t predicted_status[$];
	int        errors = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        quiet_cycles = 0;
	int        queued_in_phase = 0;
	logic [62:0] t_cur = 63'd1000;

	// Sequencer copy: configuration and state
	logic [15:0] cfg_settle_ms;
	logic [7:0]  cfg_max;
	logic [15:0] cfg_delay;
	mode_t       m_mode;
	logic        m_hold;
	logic        m_retreat;
	logic        m_retry_on;
	logic [62:0] m_stable_ns;
	logic [7:0]  m_attempts;
	logic [15:0] m_delay_left;
	logic        m_awaiting;

	function automatic void reset_sequencer();
		cfg_settle_ms = 16'd500;
		cfg_max = 8'd3;
		cfg_delay = 16'd100;
		m_mode = MODE_IDLE;
		m_hold = 1'b0;
		m_retreat = 1'b1;
		m_retry_on = 1'b0;
		m_stable_ns = '0;
		m_attempts = '0;
		m_delay_left = '0;
		m_awaiting = 1'b0;
	endfunction

	function automatic out_item_t advance_sequencer(in_item_t it);
		out_item_t r;
		logic pulse;
		longint unsigned now_ns;
		longint unsigned start_ns;
		longint unsigned win_ns;
		pulse = 1'b0;
		case (cmd_t'(it.command))
			CMD_PAUSE: begin
				m_hold = 1'b1; m_retreat = 1'b0; m_stable_ns = '0; m_mode = MODE_HOLD;
			end
			CMD_RETRACT: begin
				m_hold = 1'b0; m_retreat = 1'b1; m_stable_ns = '0; m_mode = MODE_RETRACT;
			end
			CMD_ESTOP: begin
				m_retry_on = 1'b0; m_awaiting = 1'b0;
				m_hold = 1'b0; m_retreat = 1'b0; m_stable_ns = '0; m_mode = MODE_ESTOP;
			end
			CMD_RESET: begin
				m_retry_on = 1'b0; m_awaiting = 1'b0;
				m_hold = 1'b0; m_retreat = 1'b1; m_stable_ns = '0; m_mode = MODE_IDLE;
			end
			CMD_TRIGGER: begin
				m_awaiting = 1'b0;
				m_attempts = '0;
				m_delay_left = cfg_delay;
				m_retry_on = (cfg_max != 0);
				m_stable_ns = '0;
				m_mode = MODE_HOLD;
			end
			CMD_BAND: begin
				if (m_mode != MODE_ESTOP && m_mode != MODE_IDLE) begin
					if (!it.within_band) begin
						m_stable_ns = '0;
						if (m_mode == MODE_READY)
							m_mode = MODE_WAIT;
					end else begin
						if (m_stable_ns == 0)
							m_stable_ns = it.now_time_ns;
						if (m_mode == MODE_RETRACT || m_mode == MODE_HOLD || m_mode == MODE_WAIT)
							m_mode = MODE_WAIT;
						now_ns = 64'(it.now_time_ns);
						start_ns = 64'(m_stable_ns);
						win_ns = 64'(cfg_settle_ms) * 64'd1000000;
						if (now_ns >= start_ns && now_ns - start_ns >= win_ns) begin
							m_hold = 1'b0; m_retreat = 1'b1; m_mode = MODE_READY;
						end
					end
				end
			end
			CMD_TICK: begin
				if (m_retry_on && !m_awaiting) begin
					if (m_delay_left > 1) begin
						m_delay_left = m_delay_left - 1'b1;
					end else if (m_attempts >= cfg_max) begin
						m_delay_left = '0; m_retry_on = 1'b0; m_awaiting = 1'b0;
					end else begin
						m_delay_left = '0;
						m_attempts = m_attempts + 1'b1;
						m_awaiting = 1'b1;
						pulse = 1'b1;
					end
				end
			end
			CMD_OUTCOME: begin
				if (m_retry_on && m_awaiting) begin
					m_awaiting = 1'b0;
					if (it.attempt_success) begin
						m_retry_on = 1'b0;
						m_hold = 1'b1; m_retreat = 1'b0; m_stable_ns = '0; m_mode = MODE_WAIT;
					end else if (m_attempts >= cfg_max) begin
						m_retry_on = 1'b0;
					end else begin
						m_delay_left = cfg_delay;
					end
				end
			end
			default: ;
		endcase
		r.state_code = m_mode;
		r.hold_active = m_hold;
		r.retreat_done = m_retreat;
		r.retry_running = m_retry_on;
		r.attempt_request = pulse;
		r.attempt_index = m_attempts;
		return r;
	endfunction

	task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	// Driver: hold a stalled item, otherwise advance to the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_item <= pending_cmds.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Monitor: predict on each accepted item, compare each accepted result
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predicted_status.push_back(advance_sequencer(in_item));
			if (out_valid && !out_stall) begin
				if (predicted_status.size() == 0) begin
					errors++;
					$display("%0t: result with no item pending, actual %h", $time, out_item);
				end else begin
					want = predicted_status.pop_front();
					check_field("state_code", 8'(want.state_code), 8'(out_item.state_code));
					check_field("hold_active", 8'(want.hold_active), 8'(out_item.hold_active));
					check_field("retreat_done", 8'(want.retreat_done), 8'(out_item.retreat_done));
					check_field("retry_running", 8'(want.retry_running),
						8'(out_item.retry_running));
					check_field("attempt_request", 8'(want.attempt_request),
						8'(out_item.attempt_request));
					check_field("attempt_index", want.attempt_index, out_item.attempt_index);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("tb_fault_recovery_sequencer_top NOT OK");
			$finish;
		end
	end

	function automatic logic [62:0] rand_ts();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[62:0];
	endfunction

	task automatic push_item(cmd_t c, logic w, logic [62:0] t, logic s);
		in_item_t it;
		it.command = c;
		it.within_band = w;
		it.now_time_ns = t;
		it.attempt_success = s;
		pending_cmds.push_back(it);
		queued_in_phase++;
	endtask

	task automatic push_cmd(cmd_t c);
		push_item(c, 1'($urandom_range(0, 1)), rand_ts(), 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_drain();
		while (pending_cmds.size() != 0 || in_valid || predicted_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SETTLE: cfg_settle_ms = v;
			CFG_RETRY_MAX: cfg_max = v[7:0];
			CFG_RETRY_DELAY: cfg_delay = v;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] settle, logic [7:0] max_n, logic [15:0] delay);
		wait_drain();
		write_reg(CFG_SETTLE, settle);
		write_reg(CFG_RETRY_MAX, 16'(max_n));
		write_reg(CFG_RETRY_DELAY, delay);
		queued_in_phase = 0;
	endtask

	task automatic band_run();
		int n;
		int pick;
		longint unsigned win_ns;
		longint unsigned step;
		case ($urandom_range(0, 3))
			0: push_cmd(CMD_PAUSE);
			1: push_cmd(CMD_RETRACT);
			2: push_cmd(CMD_TRIGGER);
			default: ;
		endcase
		n = $urandom_range(2, 8);
		win_ns = 64'(cfg_settle_ms) * 64'd1000000;
		repeat (n) begin
			pick = $urandom_range(0, 11);
			if (pick == 0) begin
				push_item(CMD_BAND, 1'b1, '0, 1'($urandom_range(0, 1)));
			end else if (pick == 1) begin
				push_item(CMD_BAND, 1'b1, t_cur - 63'($urandom_range(1, 1000)),
					1'($urandom_range(0, 1)));
			end else begin
				if (win_ns == 0)
					step = $urandom_range(0, 2000);
				else
					step = (win_ns * $urandom_range(0, 12)) / 8;
				t_cur = t_cur + 63'(step);
				push_item(CMD_BAND, 1'($urandom_range(0, 9) != 0), t_cur,
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic retry_run();
		int tries;
		int n_ticks;
		int k;
		push_cmd(CMD_TRIGGER);
		tries = $urandom_range(1, (cfg_max > 6 ? 6 : int'(cfg_max)) + 1);
		for (k = 0; k < tries; k++) begin
			if (cfg_delay > 12)
				n_ticks = $urandom_range(1, 12);
			else
				n_ticks = (cfg_delay == 0 ? 1 : int'(cfg_delay)) + $urandom_range(0, 1);
			repeat (n_ticks) push_cmd(CMD_TICK);
			case ($urandom_range(0, 9))
				0: push_cmd(CMD_PAUSE);
				1: push_cmd(CMD_RETRACT);
				2: push_cmd(CMD_BAND);
				default: ;
			endcase
			if ($urandom_range(0, 3) == 0) begin
				push_item(CMD_OUTCOME, 1'($urandom_range(0, 1)), rand_ts(), 1'b1);
				break;
			end
			push_item(CMD_OUTCOME, 1'($urandom_range(0, 1)), rand_ts(), 1'b0);
		end
		case ($urandom_range(0, 7))
			0: push_cmd(CMD_ESTOP);
			1: push_cmd(CMD_RESET);
			default: ;
		endcase
	endtask

	task automatic random_phase(int n);
		int pick;
		while (queued_in_phase < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)
				push_item(cmd_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), rand_ts(),
					1'($urandom_range(0, 1)));
			else if (pick < 60)
				retry_run();
			else
				band_run();
		end
	endtask

	initial begin
		reset_sequencer();
		send_idle_pct = 8;
		recv_stall_pct = 85;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: settle window and mode moves with reset configuration
		push_item(CMD_BAND, 1'b1, 63'd1000, 1'b0);
		push_item(CMD_TICK, 1'b0, '0, 1'b0);
		push_item(CMD_OUTCOME, 1'b0, '0, 1'b1);
		push_item(CMD_PAUSE, 1'b0, '0, 1'b0);
		push_item(CMD_BAND, 1'b1, '0, 1'b0);
		push_item(CMD_BAND, 1'b1, 63'd1000, 1'b0);
		push_item(CMD_BAND, 1'b1, 63'd500, 1'b0);
		push_item(CMD_BAND, 1'b1, 63'd500001000, 1'b0);
		push_item(CMD_BAND, 1'b0, '1, 1'b1);
		push_item(CMD_BAND, 1'b1, '1, 1'b1);
		push_item(CMD_RETRACT, 1'b1, '1, 1'b1);
		push_item(CMD_ESTOP, 1'b0, '0, 1'b0);
		push_item(CMD_BAND, 1'b1, 63'd5, 1'b0);
		push_item(CMD_RESET, 1'b0, '0, 1'b0);

		// Directed: zero attempts, zero settle window
		set_config(16'd0, 8'd0, 16'd0);
		push_item(CMD_TRIGGER, 1'b0, '0, 1'b0);
		push_item(CMD_TICK, 1'b0, '0, 1'b0);
		push_item(CMD_BAND, 1'b1, 63'd7, 1'b0);

		// Directed: zero delay, a failed outcome, tick while awaiting
		set_config(16'd0, 8'd2, 16'd0);
		push_item(CMD_TRIGGER, 1'b0, '0, 1'b0);
		push_item(CMD_TICK, 1'b0, '0, 1'b0);
		push_item(CMD_TICK, 1'b0, '0, 1'b0);
		push_item(CMD_OUTCOME, 1'b0, '0, 1'b0);

		// Directed: maximum lowered under a running retry, pause during retry
		set_config(16'd0, 8'd1, 16'd0);
		push_item(CMD_TICK, 1'b0, '0, 1'b0);
		push_item(CMD_TRIGGER, 1'b0, '0, 1'b0);
		push_item(CMD_TICK, 1'b0, '0, 1'b0);
		push_item(CMD_PAUSE, 1'b0, '0, 1'b0);
		push_item(CMD_OUTCOME, 1'b0, '0, 1'b1);

		set_config(16'd1, 8'd255, 16'd1);
		random_phase(130);
		set_config(16'($urandom_range(0, 20)), 8'($urandom_range(0, 6)),
			16'($urandom_range(0, 5)));
		random_phase(120);

		wait_drain();
		send_idle_pct = 85;
		recv_stall_pct = 8;
		set_config(16'd65535, 8'd3, 16'd2);
		random_phase(130);
		set_config(16'd2, 8'd1, 16'd65535);
		random_phase(60);

		wait_drain();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(16'd0, 8'd4, 16'd0);
		random_phase(150);
		set_config(16'($urandom_range(0, 20)), 8'($urandom_range(0, 6)),
			16'($urandom_range(0, 5)));
		random_phase(160);

		wait_drain();
		repeat (8) @(posedge clk);
		if (predicted_status.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, predicted_status.size());
		end
		if (errors == 0)
			$display("tb_fault_recovery_sequencer_top OK");
		else
			$display("tb_fault_recovery_sequencer_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
